// ===== hw/rtl/pwsa_pkg.sv =====
// Package for the perspective warp source address unit.
// Holds field widths, image bounds, register indexes, the divider stage type and the divide step.
// No dependencies.
package pwsa_pkg;

   localparam int COEF_W    = 48;
   localparam int COORD_W   = 12;
   localparam int NUM_COEFS = 8;
   localparam int CSR_IDX_W = 3;
   localparam int PROD_W    = COEF_W + COORD_W + 1;   // signed coef * unsigned coord
   localparam int SUM_W     = PROD_W + 1;             // three terms
   localparam int MAG_W     = SUM_W;                  // magnitude of a SUM_W signed value
   localparam int QUO_W     = COORD_W;                // quotient bits below the overflow limit
   localparam int SHIFT_W   = MAG_W + QUO_W;          // divisor shifted by up to QUO_W
   localparam int RND_W     = QUO_W + 1;

   localparam logic [RND_W-1:0] SRC_WIDTH  = RND_W'(2048);
   localparam logic [RND_W-1:0] SRC_HEIGHT = RND_W'(2048);

   localparam logic signed [COEF_W-1:0] ONE_Q24 = COEF_W'(64'd16777216);

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_XX = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_XY = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_XT = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_YX = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_YY = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_YT = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_WX = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_WY = 3'd7;

   // one request moving through the restoring divider
   typedef struct packed {
      logic [MAG_W-1:0] rem_x;
      logic [MAG_W-1:0] rem_y;
      logic [MAG_W-1:0] den;
      logic [QUO_W-1:0] quo_x;
      logic [QUO_W-1:0] quo_y;
      logic             neg_x;
      logic             neg_y;
      logic             zero;
      logic             ovf_x;
      logic             ovf_y;
   } div_stage_type;

   // one restoring step for quotient bit pos, both axes share the divisor
   function automatic div_stage_type div_step(input div_stage_type s, input int pos);
      div_stage_type        r;
      logic [SHIFT_W-1:0]   dsh;
      r   = s;
      dsh = SHIFT_W'(s.den) << pos;
      if (SHIFT_W'(s.rem_x) >= dsh) begin
         r.rem_x      = s.rem_x - dsh[MAG_W-1:0];
         r.quo_x[pos] = 1'b1;
      end
      if (SHIFT_W'(s.rem_y) >= dsh) begin
         r.rem_y      = s.rem_y - dsh[MAG_W-1:0];
         r.quo_y[pos] = 1'b1;
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/perspective_warp_source_address.sv =====
// Inverse perspective warp, nearest source pixel address.
// Accepts one request per cycle while the output is not stalled.
// The pipe is 6 multipliers, a sum stage, a magnitude stage, an overflow check,
// 12 one-bit restoring divide steps and a rounding stage; a stalled output holds every stage.
// Synchronous active-high reset clears all valid bits and loads the identity matrix.
// Depends on pwsa_pkg.
module perspective_warp_source_address_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,    // dest_x[11:0], dest_y[23:12]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // src_x[11:0], src_y[23:12]
   output logic        rsp_tuser,    // inside_res[0]
   input  logic        csr_we,
   input  logic [pwsa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [pwsa_pkg::COEF_W-1:0]    csr_wdata
);

   localparam int NDIV = pwsa_pkg::QUO_W + 1;   // overflow check plus quotient bits

   logic signed [pwsa_pkg::COEF_W-1:0] coef_ff [pwsa_pkg::NUM_COEFS];
   logic advance;

   // stage 1: products
   logic v1_ff;
   logic signed [pwsa_pkg::PROD_W-1:0] p_ff [6];
   // stage 2: sums
   logic v2_ff;
   logic signed [pwsa_pkg::SUM_W-1:0] nx_ff, ny_ff, nw_ff;
   // stage 3: magnitudes
   logic v3_ff;
   pwsa_pkg::div_stage_type mag_ff;
   // divider stages
   logic [NDIV-1:0] vd_ff;
   pwsa_pkg::div_stage_type div_ff [NDIV];
   pwsa_pkg::div_stage_type div_in [NDIV];
   // output
   logic rsp_valid_ff;
   logic [pwsa_pkg::COORD_W-1:0] src_x_ff, src_y_ff;
   logic inside_ff;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {src_y_ff, src_x_ff};
   assign rsp_tuser  = inside_ff;

   // coefficient registers
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pwsa_pkg::NUM_COEFS; i++) begin
            coef_ff[i] <= (i == int'(pwsa_pkg::REG_XX) || i == int'(pwsa_pkg::REG_YY)) ?
                          pwsa_pkg::ONE_Q24 : '0;
         end
      end else if (csr_we) begin
         coef_ff[csr_index] <= csr_wdata;
      end
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         vd_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         v1_ff        <= req_tvalid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         vd_ff        <= {vd_ff[NDIV-2:0], v3_ff};
         rsp_valid_ff <= vd_ff[NDIV-1];
      end
   end

   // stage 1: coefficient times coordinate
   logic signed [pwsa_pkg::COORD_W:0] dx_s, dy_s;
   assign dx_s = {1'b0, req_tdata[11:0]};
   assign dy_s = {1'b0, req_tdata[23:12]};

   always_ff @(posedge clock) begin
      if (advance) begin
         p_ff[0] <= coef_ff[pwsa_pkg::REG_XX] * dx_s;
         p_ff[1] <= coef_ff[pwsa_pkg::REG_XY] * dy_s;
         p_ff[2] <= coef_ff[pwsa_pkg::REG_YX] * dx_s;
         p_ff[3] <= coef_ff[pwsa_pkg::REG_YY] * dy_s;
         p_ff[4] <= coef_ff[pwsa_pkg::REG_WX] * dx_s;
         p_ff[5] <= coef_ff[pwsa_pkg::REG_WY] * dy_s;
      end
   end

   // stage 2: numerators and denominator
   always_ff @(posedge clock) begin
      if (advance) begin
         nx_ff <= pwsa_pkg::SUM_W'(p_ff[0]) + pwsa_pkg::SUM_W'(p_ff[1])
                + pwsa_pkg::SUM_W'(coef_ff[pwsa_pkg::REG_XT]);
         ny_ff <= pwsa_pkg::SUM_W'(p_ff[2]) + pwsa_pkg::SUM_W'(p_ff[3])
                + pwsa_pkg::SUM_W'(coef_ff[pwsa_pkg::REG_YT]);
         nw_ff <= pwsa_pkg::SUM_W'(p_ff[4]) + pwsa_pkg::SUM_W'(p_ff[5])
                + pwsa_pkg::SUM_W'(pwsa_pkg::ONE_Q24);
      end
   end

   // stage 3: sign and magnitude
   pwsa_pkg::div_stage_type mag_in;
   always_comb begin
      mag_in       = '0;
      mag_in.rem_x = nx_ff[pwsa_pkg::SUM_W-1] ? pwsa_pkg::MAG_W'(-nx_ff)
                                               : pwsa_pkg::MAG_W'(nx_ff);
      mag_in.rem_y = ny_ff[pwsa_pkg::SUM_W-1] ? pwsa_pkg::MAG_W'(-ny_ff)
                                               : pwsa_pkg::MAG_W'(ny_ff);
      mag_in.den   = nw_ff[pwsa_pkg::SUM_W-1] ? pwsa_pkg::MAG_W'(-nw_ff)
                                               : pwsa_pkg::MAG_W'(nw_ff);
      mag_in.neg_x = nx_ff[pwsa_pkg::SUM_W-1] ^ nw_ff[pwsa_pkg::SUM_W-1];
      mag_in.neg_y = ny_ff[pwsa_pkg::SUM_W-1] ^ nw_ff[pwsa_pkg::SUM_W-1];
      mag_in.zero  = (nw_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (advance) mag_ff <= mag_in;
   end

   // divider: first stage flags quotients of 4096 or more, then one bit per stage
   always_comb begin
      logic [pwsa_pkg::SHIFT_W-1:0] lim;
      lim          = pwsa_pkg::SHIFT_W'(mag_ff.den) << pwsa_pkg::QUO_W;
      div_in[0]       = mag_ff;
      div_in[0].ovf_x = pwsa_pkg::SHIFT_W'(mag_ff.rem_x) >= lim;
      div_in[0].ovf_y = pwsa_pkg::SHIFT_W'(mag_ff.rem_y) >= lim;
      for (int k = 1; k < NDIV; k++) begin
         div_in[k] = pwsa_pkg::div_step(div_ff[k-1], pwsa_pkg::QUO_W - k);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int k = 0; k < NDIV; k++) div_ff[k] <= div_in[k];
      end
   end

   // rounding and bounds check
   pwsa_pkg::div_stage_type fin;
   logic [pwsa_pkg::RND_W-1:0] mx, my;
   logic okx, oky, in_image;
   always_comb begin
      fin = div_ff[NDIV-1];
      mx  = pwsa_pkg::RND_W'(fin.quo_x)
          + pwsa_pkg::RND_W'({fin.rem_x, 1'b0} >= {1'b0, fin.den});
      my  = pwsa_pkg::RND_W'(fin.quo_y)
          + pwsa_pkg::RND_W'({fin.rem_y, 1'b0} >= {1'b0, fin.den});
      okx = !fin.ovf_x && ((mx == '0) || (!fin.neg_x && (mx < pwsa_pkg::SRC_WIDTH)));
      oky = !fin.ovf_y && ((my == '0) || (!fin.neg_y && (my < pwsa_pkg::SRC_HEIGHT)));
      in_image = !fin.zero && okx && oky;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         inside_ff <= in_image;
         src_x_ff  <= in_image ? mx[pwsa_pkg::COORD_W-1:0] : '0;
         src_y_ff  <= in_image ? my[pwsa_pkg::COORD_W-1:0] : '0;
      end
   end

endmodule

// ===== hw/rtl/pwsa_checker.sv =====
// Port-level checker for perspective_warp_source_address_unit, bound to the top level.
// Port widths are written as literals; it does not use pwsa_pkg.
module pwsa_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tuser
);

   // a held result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // an address outside the image reads as zero
   a_zero_out: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata == 24'd0)
      else $error("nonzero address with inside clear");

   // the pipe only stalls on a waiting result
   a_ready: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("request ready does not follow output stall");

   // nothing comes out right after reset
   a_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

bind perspective_warp_source_address_unit pwsa_checker u_pwsa_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

// ===== test/perspective_warp_source_address_unit_tb.sv =====
// Testbench for perspective_warp_source_address_unit: predicts each source address
// in a local model of the inverse warp and checks every result in order.
// Depends on pwsa_pkg and the RTL of the unit.
`timescale 1ns / 1ps

module perspective_warp_source_address_unit_tb;

   localparam int ONE        = 1 << 24;
   localparam int IDLE_LIMIT = 3000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [23:0]          req_tdata = '0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [23:0]          rsp_tdata;
   logic                 rsp_tuser;
   logic                 csr_we = 1'b0;
   logic [pwsa_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [pwsa_pkg::COEF_W-1:0]    csr_wdata = '0;

   // local copy of the loaded inverse matrix
   logic signed [pwsa_pkg::COEF_W-1:0] matrix [pwsa_pkg::NUM_COEFS];
   // predicted {inside, src_y, src_x} per accepted request
   logic [24:0]              addr_expected [$];

   int  error_count = 0;
   int  sent_count = 0;
   int  checked_count = 0;
   int  inside_count = 0;
   int  idle_cycles = 0;
   int  stall_len = 0;
   bit  quiet = 1'b0;

   perspective_warp_source_address_unit i_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // rounded num/den, ok when the value lands in [0, 2048)
   function automatic void round_coord(input longint num, input longint den,
                                       output bit ok, output logic [11:0] val);
      longint unsigned a, b, ip, rem, m;
      bit neg;
      a   = num < 0 ? -num : num;
      b   = den < 0 ? -den : den;
      neg = (num < 0) != (den < 0);
      ip  = a / b;
      rem = a - ip * b;
      m   = ip + (((rem << 1) >= b) ? 1 : 0);
      val = '0;
      ok  = 1'b1;
      if (m != 0) begin
         if (neg || m >= 2048) ok = 1'b0;
         else val = m[11:0];
      end
   endfunction

   function automatic logic [24:0] predict_source(input logic [11:0] x, input logic [11:0] y);
      longint xi, yi, nx, ny, nw;
      bit okx, oky;
      logic [11:0] sx, sy;
      xi = x;
      yi = y;
      nx = longint'(matrix[pwsa_pkg::REG_XX]) * xi + longint'(matrix[pwsa_pkg::REG_XY]) * yi
           + longint'(matrix[pwsa_pkg::REG_XT]);
      ny = longint'(matrix[pwsa_pkg::REG_YX]) * xi + longint'(matrix[pwsa_pkg::REG_YY]) * yi
           + longint'(matrix[pwsa_pkg::REG_YT]);
      nw = longint'(matrix[pwsa_pkg::REG_WX]) * xi + longint'(matrix[pwsa_pkg::REG_WY]) * yi
           + ONE;
      if (nw == 0) return '0;
      round_coord(nx, nw, okx, sx);
      round_coord(ny, nw, oky, sy);
      if (!(okx && oky)) return '0;
      return {1'b1, sy, sx};
   endfunction

   task automatic report(input string what, input longint got, input longint want);
      $display("MISMATCH %s: got %0d expected %0d (result %0d)", what, got, want,
               checked_count);
      error_count++;
   endtask

   // one request; caller lowers valid when done sending
   task automatic send_request(input logic [11:0] x, input logic [11:0] y);
      while (!quiet && $urandom_range(99) < 13) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {y, x};
      do @(posedge clock); while (!req_tready);
      addr_expected.push_back(predict_source(x, y));
      sent_count++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      wait (addr_expected.size() == 0);
      repeat (24) @(posedge clock);
   endtask

   task automatic load_matrix(input logic [pwsa_pkg::COEF_W-1:0] m [pwsa_pkg::NUM_COEFS]);
      for (int i = 0; i < pwsa_pkg::NUM_COEFS; i++) begin
         @(negedge clock);
         csr_we    <= 1'b1;
         csr_index <= pwsa_pkg::CSR_IDX_W'(i);
         csr_wdata <= m[i];
         matrix[i] = m[i];
      end
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   function automatic logic [pwsa_pkg::COEF_W-1:0] rand_bits(input int bits);
      logic [63:0] r;
      r = {$urandom, $urandom};
      r = r & ((64'd1 << bits) - 1);
      if ($urandom_range(1)) r = -r;
      return r[pwsa_pkg::COEF_W-1:0];
   endfunction

   // random inverse matrix: mostly mild warps that map into the image
   function automatic void rand_matrix(output logic [pwsa_pkg::COEF_W-1:0] m [pwsa_pkg::NUM_COEFS]);
      int kind;
      kind = $urandom_range(4);
      for (int i = 0; i < pwsa_pkg::NUM_COEFS; i++) begin
         case (kind)
            0, 1, 2: m[i] = (i == pwsa_pkg::REG_XT || i == pwsa_pkg::REG_YT) ? rand_bits(34) :
                            (i == pwsa_pkg::REG_WX || i == pwsa_pkg::REG_WY) ? rand_bits(13) :
                            rand_bits(24);
            3:       m[i] = pwsa_pkg::COEF_W'({$urandom, $urandom});
            default: case ($urandom_range(2))
                        0: m[i] = {1'b0, {(pwsa_pkg::COEF_W-1){1'b1}}};
                        1: m[i] = {1'b1, {(pwsa_pkg::COEF_W-1){1'b0}}};
                        default: m[i] = rand_bits($urandom_range(1, 40));
                     endcase
         endcase
      end
   endfunction

   // identity after reset, image corners and the first column outside
   task automatic test_reset_identity();
      send_request(12'd0, 12'd0);
      send_request(12'd4095, 12'd0);
      send_request(12'd0, 12'd4095);
      send_request(12'd2047, 12'd2047);
      send_request(12'd2048, 12'd5);
      send_request(12'd4095, 12'd4095);
      drain();
   endtask

   // half scale: exact halves round away from zero, small negatives round to zero
   task automatic test_half_rounding();
      logic [pwsa_pkg::COEF_W-1:0] m [pwsa_pkg::NUM_COEFS];
      m = '{default: '0};
      m[pwsa_pkg::REG_XX] = pwsa_pkg::COEF_W'(ONE / 2);
      m[pwsa_pkg::REG_YY] = pwsa_pkg::COEF_W'(ONE / 2);
      m[pwsa_pkg::REG_YT] = pwsa_pkg::COEF_W'(-(ONE / 4));
      load_matrix(m);
      send_request(12'd1, 12'd0);
      send_request(12'd3, 12'd1);
      send_request(12'd4094, 12'd4095);
      send_request(12'd0, 12'd4);
      drain();
      m[pwsa_pkg::REG_YT] = pwsa_pkg::COEF_W'(-ONE);
      load_matrix(m);
      send_request(12'd1, 12'd1);
      send_request(12'd5, 12'd0);
      drain();
   endtask

   // nw = 1 - x: zero at x=1, negative beyond
   task automatic test_denominator_sign();
      logic [pwsa_pkg::COEF_W-1:0] m [pwsa_pkg::NUM_COEFS];
      m = '{default: '0};
      m[pwsa_pkg::REG_XX] = pwsa_pkg::COEF_W'(-ONE);
      m[pwsa_pkg::REG_YY] = pwsa_pkg::COEF_W'(ONE);
      m[pwsa_pkg::REG_WX] = pwsa_pkg::COEF_W'(-ONE);
      load_matrix(m);
      send_request(12'd0, 12'd5);
      send_request(12'd1, 12'd7);
      send_request(12'd2, 12'd0);
      send_request(12'd3, 12'd3);
      drain();
   endtask

   // coefficient extremes, huge quotients and huge denominators
   task automatic test_coef_extremes();
      logic [pwsa_pkg::COEF_W-1:0] m [pwsa_pkg::NUM_COEFS];
      m = '{default: {1'b0, {(pwsa_pkg::COEF_W-1){1'b1}}}};
      m[pwsa_pkg::REG_WX] = {1'b1, {(pwsa_pkg::COEF_W-1){1'b0}}};
      m[pwsa_pkg::REG_WY] = {1'b1, {(pwsa_pkg::COEF_W-1){1'b0}}};
      load_matrix(m);
      send_request(12'd4095, 12'd4095);
      send_request(12'd0, 12'd0);
      send_request(12'd1, 12'd0);
      drain();
      m = '{default: {1'b1, {(pwsa_pkg::COEF_W-1){1'b0}}}};
      m[pwsa_pkg::REG_WX] = '0;
      m[pwsa_pkg::REG_WY] = '0;
      load_matrix(m);
      send_request(12'd4095, 12'd4095);
      send_request(12'd0, 12'd0);
      send_request(12'd0, 12'd1);
      drain();
   endtask

   // receiver holds off long enough to fill the pipe and stall the input
   task automatic test_backpressure();
      logic [pwsa_pkg::COEF_W-1:0] m [pwsa_pkg::NUM_COEFS];
      rand_matrix(m);
      load_matrix(m);
      stall_len = 300;
      for (int i = 0; i < 60; i++) send_request(12'($urandom), 12'($urandom));
      drain();
   endtask

   task automatic test_random_phases();
      logic [pwsa_pkg::COEF_W-1:0] m [pwsa_pkg::NUM_COEFS];
      for (int p = 0; p < 8; p++) begin
         rand_matrix(m);
         load_matrix(m);
         quiet = (p == 3);
         for (int i = 0; i < 95; i++) begin
            if ($urandom_range(3) == 0)
               send_request(12'($urandom), 12'($urandom));
            else
               send_request(12'($urandom_range(2100)), 12'($urandom_range(2100)));
         end
         drain();
      end
      quiet = 1'b0;
   endtask

   // receiver readiness, with the counted hold-off
   always @(negedge clock) begin
      if (stall_len > 0) begin
         rsp_tready <= 1'b0;
         stall_len--;
      end else begin
         rsp_tready <= quiet ? 1'b1 : ($urandom_range(99) >= 13);
      end
   end

   // compare each result with the oldest prediction
   always @(posedge clock) begin
      logic [24:0] want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (addr_expected.size() == 0) begin
            report("unexpected result", rsp_tdata, 0);
         end else begin
            want = addr_expected.pop_front();
            if (rsp_tdata[11:0] !== want[11:0]) report("src_x", rsp_tdata[11:0], want[11:0]);
            if (rsp_tdata[23:12] !== want[23:12])
               report("src_y", rsp_tdata[23:12], want[23:12]);
            if (rsp_tuser !== want[24]) report("inside", rsp_tuser, want[24]);
            if (want[24]) inside_count++;
         end
         checked_count++;
      end
   end

   // watchdog on cycles with no request, result or register write moving
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > IDLE_LIMIT) begin
         $display("timeout: no traffic for %0d cycles", IDLE_LIMIT);
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      matrix = '{default: '0};
      matrix[pwsa_pkg::REG_XX] = pwsa_pkg::COEF_W'(ONE);
      matrix[pwsa_pkg::REG_YY] = pwsa_pkg::COEF_W'(ONE);
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_reset_identity();
      test_half_rounding();
      test_denominator_sign();
      test_coef_extremes();
      test_backpressure();
      test_random_phases();
      $display("covered %0d requests, %0d results checked, %0d inside the image",
               sent_count, checked_count, inside_count);
      $display("matrices: identity, half scale, zero/negative w, extremes, random warps");
      if (error_count == 0 && addr_expected.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
